@@ rtl/core/tpt_pkg.sv @@
package tpt_pkg;

	// request codes
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_ERASE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] peer_address;
		logic [7:0]  address_kind;
		logic [63:0] key_high;
		logic [63:0] key_low;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [2:0] slot;
		logic [3:0] entry_count;
	} rsp_t;

	// one stored peer
	typedef struct packed {
		logic [47:0] addr;
		logic [7:0]  kind;
		logic [63:0] key_high;
		logic [63:0] key_low;
	} entry_t;

	// per-cell controls from the sequencer
	typedef struct packed {
		logic valid;
		logic cmp;
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

@@ rtl/core/tpt_cell.sv @@
module tpt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tpt_pkg::cell_ctrl_t ctrl,
	input  tpt_pkg::entry_t     new_entry,
	input  tpt_pkg::entry_t     next_entry,
	output tpt_pkg::entry_t     entry,
	output logic                match
);

	tpt_pkg::entry_t entry_q;
	logic            match_q;

	// hold the entry; load a new one or take the upper neighbor's on a shift
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	// register the address compare for valid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp) begin
			match_q <= ctrl.valid && (entry_q.addr == new_entry.addr);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

@@ rtl/core/trusted_peer_table.sv @@
// Trusted peer table: a packed list of up to ENTRIES peers (address, kind, key)
// held in a row of cells, one entry per cell.
// Request channel: drive req and raise start; the request is taken at the
// rising edge where start is high and busy is low. busy stays high while the
// request is in work.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver takes it at the end of that cycle and cannot stall it.
// Steps: done rises after the compare in every cell, the first-match select
// and the update; a new request can be taken at the same edge at which the
// result is taken, so one request is finished before the next is taken.
// Remove moves every later cell down by one in the update step, each cell
// taking its upper neighbor's entry.
// Reset clears the entry count and the sequencer; entry contents are left
// as they are and are never read before being written.
module trusted_peer_table #(
	parameter int ENTRIES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tpt_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output tpt_pkg::rsp_t  rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]          state_q;
	tpt_pkg::req_t       req_q;
	logic [CW-1:0]       count_q;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic                done_q;
	tpt_pkg::rsp_t       rsp_q;

	tpt_pkg::entry_t     new_entry;
	tpt_pkg::entry_t     cell_entry [ENTRIES];
	tpt_pkg::cell_ctrl_t cell_ctrl  [ENTRIES];
	logic [ENTRIES-1:0]  cell_match;

	logic                first_any;
	logic [IW-1:0]       first_idx;
	logic                full;
	logic [CW-1:0]       count_nx;
	tpt_pkg::rsp_t       rsp_nx;
	logic [31:0]         slot_w;
	logic [31:0]         count_w;

	assign new_entry = '{addr: req_q.peer_address, kind: req_q.address_kind,
		key_high: req_q.key_high, key_low: req_q.key_low};

	assign full = (count_q == CW'(ENTRIES));

	// row of cells, each fed by its upper neighbor
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tpt_pkg::entry_t next_e;
		if (i == ENTRIES - 1) begin : g_last
			assign next_e = cell_entry[i];
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end
		tpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[i]),
			.new_entry  (new_entry),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.match      (cell_match[i])
		);
	end

	// select the lowest matching cell
	always_comb begin
		first_any = 1'b0;
		first_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				first_any = 1'b1;
				first_idx = IW'(i);
			end
		end
	end

	// drive cell controls for the compare and update steps
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			cell_ctrl[i].valid = (32'(i) < 32'(count_q));
			cell_ctrl[i].cmp   = (state_q == S_CMP);
			cell_ctrl[i].load  = 1'b0;
			cell_ctrl[i].shift = 1'b0;
			if (state_q == S_UPD) begin
				case (req_q.mode)
					tpt_pkg::MODE_ADD: begin
						if (!full) begin
							if (hit_q) begin
								cell_ctrl[i].load = (IW'(i) == hit_idx_q);
							end else begin
								cell_ctrl[i].load = (32'(i) == 32'(count_q));
							end
						end
					end
					tpt_pkg::MODE_REMOVE: begin
						cell_ctrl[i].shift = hit_q && (IW'(i) >= hit_idx_q)
							&& (32'(i) + 32'd1 < 32'(count_q));
					end
					default: begin
						cell_ctrl[i].load = 1'b0;
					end
				endcase
			end
		end
	end

	// build the result and the next entry count
	always_comb begin
		count_nx = count_q;
		slot_w   = 32'd0;
		rsp_nx   = '{status: tpt_pkg::ST_OK, hit: 1'b0, slot: 3'd0, entry_count: 4'd0};
		case (req_q.mode)
			tpt_pkg::MODE_LOOKUP: begin
				rsp_nx.hit = hit_q;
				if (hit_q) begin
					slot_w = 32'(hit_idx_q);
				end else begin
					rsp_nx.status = tpt_pkg::ST_NOT_FOUND;
				end
			end
			tpt_pkg::MODE_ADD: begin
				if (full) begin
					rsp_nx.status = tpt_pkg::ST_FULL;
				end else if (hit_q) begin
					rsp_nx.hit = 1'b1;
					slot_w     = 32'(hit_idx_q);
				end else begin
					slot_w   = 32'(count_q);
					count_nx = count_q + CW'(1);
				end
			end
			tpt_pkg::MODE_REMOVE: begin
				rsp_nx.hit = hit_q;
				if (hit_q) begin
					slot_w   = 32'(hit_idx_q);
					count_nx = count_q - CW'(1);
				end else begin
					rsp_nx.status = tpt_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				count_nx = '0;
			end
		endcase
		count_w            = 32'(count_nx);
		rsp_nx.slot        = slot_w[2:0];
		rsp_nx.entry_count = count_w[3:0];
	end

	// advance the sequencer and hold the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_RES;
				end
				S_RES: begin
					hit_q   <= first_any;
					state_q <= S_UPD;
				end
				S_UPD: begin
					count_q <= count_nx;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// capture the request, the match index and the result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_RES) begin
			hit_idx_q <= first_idx;
		end
		if (state_q == S_UPD) begin
			rsp_q <= rsp_nx;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ rtl/core/tpt_checker.sv @@
module tpt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input tpt_pkg::rsp_t rsp
);

	// a result is only shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// an accepted request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");

	// every accepted request is followed by its done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("result missing");

	// a full-table refusal reports neither hit nor slot
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == tpt_pkg::ST_FULL) |-> (!rsp.hit && rsp.slot == 3'd0))
		else $error("full result carries hit or slot");

	// a miss never reports a hit
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == tpt_pkg::ST_NOT_FOUND) |-> !rsp.hit)
		else $error("miss with hit");

endmodule

bind trusted_peer_table tpt_checker u_tpt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int TABLE_DEPTH = 8;
	localparam int POOL_SIZE   = 12;
	localparam int MAX_GAP     = 13;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 200000;

	logic          clk;
	logic          arst_n;
	logic          start;
	tpt_pkg::req_t req;
	logic          busy;
	logic          done;
	tpt_pkg::rsp_t rsp;

	trusted_peer_table #(
		.ENTRIES(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// predicted table contents and the results still owed by the block
	tpt_pkg::entry_t peer_table [TABLE_DEPTH];
	int              peer_count;
	tpt_pkg::rsp_t   awaited_rsp [$];

	logic [47:0] addr_pool [POOL_SIZE];
	bit          no_idle;

	int cycle_count;
	int fail_count;
	int requests_sent;
	int hit_seen;
	int miss_seen;
	int full_seen;
	int erase_seen;
	int peak_count;

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// end the run if the block stops answering
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [3:0] got,
			input logic [3:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// apply one request to the predicted table and form its result
	task automatic apply_to_table(input tpt_pkg::req_t r, output tpt_pkg::rsp_t e);
		int idx;
		idx = -1;
		e = '0;
		for (int i = 0; i < peer_count; i++)
			if (idx < 0 && peer_table[i].addr == r.peer_address)
				idx = i;
		case (r.mode)
			tpt_pkg::MODE_LOOKUP: begin
				if (idx >= 0) begin
					e.hit = 1'b1;
					e.slot = 3'(idx);
				end else begin
					e.status = tpt_pkg::ST_NOT_FOUND;
				end
			end
			tpt_pkg::MODE_ADD: begin
				if (peer_count >= TABLE_DEPTH) begin
					// full wins even over an address already present
					e.status = tpt_pkg::ST_FULL;
				end else if (idx >= 0) begin
					peer_table[idx].kind = r.address_kind;
					peer_table[idx].key_high = r.key_high;
					peer_table[idx].key_low = r.key_low;
					e.hit = 1'b1;
					e.slot = 3'(idx);
				end else begin
					peer_table[peer_count] = '{r.peer_address, r.address_kind,
						r.key_high, r.key_low};
					e.slot = 3'(peer_count);
					peer_count++;
				end
			end
			tpt_pkg::MODE_REMOVE: begin
				if (idx < 0) begin
					e.status = tpt_pkg::ST_NOT_FOUND;
				end else begin
					// close the gap left by the removed entry
					for (int i = idx; i + 1 < peer_count; i++)
						peer_table[i] = peer_table[i + 1];
					peer_count--;
					e.hit = 1'b1;
					e.slot = 3'(idx);
				end
			end
			default: begin
				peer_count = 0;
			end
		endcase
		e.entry_count = 4'(peer_count);
		if (peer_count > peak_count)
			peak_count = peer_count;
	endtask

	// hold the request until the block takes it, then record the expected result
	task automatic send_request(input tpt_pkg::req_t r);
		int            gap;
		bit            taken;
		tpt_pkg::rsp_t e;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = (busy === 1'b0);
		end
		apply_to_table(r, e);
		awaited_rsp.push_back(e);
		requests_sent++;
		if (r.mode == tpt_pkg::MODE_ERASE)
			erase_seen++;
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		tpt_pkg::rsp_t e;
		if (arst_n && done === 1'b1) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("result with no request waiting");
			end else begin
				e = awaited_rsp.pop_front();
				check_field("status", 4'(rsp.status), 4'(e.status));
				check_field("hit", 4'(rsp.hit), 4'(e.hit));
				check_field("slot", 4'(rsp.slot), 4'(e.slot));
				check_field("entry_count", rsp.entry_count, e.entry_count);
				if (e.hit)
					hit_seen++;
				if (e.status == tpt_pkg::ST_NOT_FOUND)
					miss_seen++;
				if (e.status == tpt_pkg::ST_FULL)
					full_seen++;
			end
		end
	end

	function automatic tpt_pkg::req_t make_request(input logic [1:0] mode,
			input logic [47:0] addr, input logic [7:0] kind,
			input logic [63:0] khi, input logic [63:0] klo);
		tpt_pkg::req_t r;
		r = '{mode, addr, kind, khi, klo};
		return r;
	endfunction

	// draw a request, mostly on pooled addresses so that matches are common
	function automatic tpt_pkg::req_t random_request(input int add_pct, input int look_pct,
			input int rem_pct);
		tpt_pkg::req_t r;
		int            pick;
		int            sel;
		pick = $urandom_range(0, 99);
		if (pick < add_pct)
			r.mode = tpt_pkg::MODE_ADD;
		else if (pick < add_pct + look_pct)
			r.mode = tpt_pkg::MODE_LOOKUP;
		else if (pick < add_pct + look_pct + rem_pct)
			r.mode = tpt_pkg::MODE_REMOVE;
		else
			r.mode = tpt_pkg::MODE_ERASE;
		sel = $urandom_range(0, 19);
		if (sel < 17)
			r.peer_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (sel < 19)
			r.peer_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)]
				^ (48'h1 << $urandom_range(0, 47));
		else
			r.peer_address = {16'($urandom()), $urandom()};
		r.address_kind = 8'($urandom());
		r.key_high = {$urandom(), $urandom()};
		r.key_low = {$urandom(), $urandom()};
		return r;
	endfunction

	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = {16'($urandom()), $urandom()};
		no_idle = ($urandom_range(0, 3) == 0);
	endtask

	task automatic test_directed();
		logic [47:0] ones;
		logic [63:0] kones;
		ones = '1;
		kones = '1;
		no_idle = 1'b0;
		// empty table: misses and an erase with nothing stored
		send_request(make_request(tpt_pkg::MODE_LOOKUP, ones, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_REMOVE, 48'h0, 8'hff, kones, kones));
		send_request(make_request(tpt_pkg::MODE_ERASE, 48'h0, 8'h00, 64'h0, 64'h0));
		// extremes of address, kind and key
		send_request(make_request(tpt_pkg::MODE_ADD, 48'h0, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_ADD, ones, 8'hff, kones, kones));
		// update in place of a present address
		send_request(make_request(tpt_pkg::MODE_ADD, 48'h0, 8'h5a, kones, 64'h0));
		send_request(make_request(tpt_pkg::MODE_LOOKUP, ones, 8'h00, 64'h0, 64'h0));
		// fill the table
		for (int k = 0; k < TABLE_DEPTH - 2; k++)
			send_request(make_request(tpt_pkg::MODE_ADD, 48'h1 << (k * 8), 8'(k),
				{$urandom(), $urandom()}, {$urandom(), $urandom()}));
		// full: a new address and a present address are both refused
		send_request(make_request(tpt_pkg::MODE_ADD, 48'h123456789abc, 8'h11,
			64'h1, 64'h2));
		send_request(make_request(tpt_pkg::MODE_ADD, 48'h0, 8'h22, 64'h3, 64'h4));
		send_request(make_request(tpt_pkg::MODE_LOOKUP, 48'h1 << 40, 8'h00,
			64'h0, 64'h0));
		// remove the first entry and watch the rest move down
		send_request(make_request(tpt_pkg::MODE_REMOVE, 48'h0, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_LOOKUP, ones, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_LOOKUP, 48'h1 << 40, 8'h00,
			64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_REMOVE, 48'h1 << 40, 8'h00,
			64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_REMOVE, 48'h0, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_ADD, 48'hfedcba987654, 8'h80,
			kones, 64'h1));
		// erase all, then reuse from slot zero
		send_request(make_request(tpt_pkg::MODE_ERASE, ones, 8'hff, kones, kones));
		send_request(make_request(tpt_pkg::MODE_LOOKUP, ones, 8'h00, 64'h0, 64'h0));
		send_request(make_request(tpt_pkg::MODE_ADD, ones, 8'h01, 64'h0, kones));
	endtask

	// add-heavy traffic that keeps the table near or at full
	task automatic test_random_fill();
		for (int b = 0; b < 8; b++) begin
			refresh_pool();
			for (int n = 0; n < 75; n++)
				send_request(random_request(60, 20, 17));
		end
	endtask

	// mixed traffic whose balance of adds and removes changes per burst
	task automatic test_random_churn();
		int add_pct;
		for (int b = 0; b < 21; b++) begin
			refresh_pool();
			add_pct = $urandom_range(25, 55);
			for (int n = 0; n < 50; n++)
				send_request(random_request(add_pct, 25, 97 - add_pct - 25));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		peer_count = 0;
		fail_count = 0;
		requests_sent = 0;
		hit_seen = 0;
		miss_seen = 0;
		full_seen = 0;
		erase_seen = 0;
		peak_count = 0;
		no_idle = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_fill();
		test_random_churn();

		// drop start and let the last results come back
		@(negedge clk) start <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d requests: %0d hits, %0d not found, %0d refused as full.",
			requests_sent, hit_seen, miss_seen, full_seen);
		$display("Table peaked at %0d entries; %0d erase-all requests.",
			peak_count, erase_seen);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tpt_pkg.sv
rtl/core/tpt_cell.sv
rtl/core/trusted_peer_table.sv
rtl/core/tpt_checker.sv
bench/testbench.sv
